>>> hw/rtl/separable_box_blur_assert.svh
// ----------------------------------------------------------------------------
// Separable box blur assertion macros
// Concurrent assertion helpers shared by the blur RTL, clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BOX_BLUR_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sbb_pkg.sv
// ----------------------------------------------------------------------------
// Separable box blur package
// Field widths, register indexes, request codes and default sizes.
// ----------------------------------------------------------------------------
package sbb_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_MAX_RADIUS = 63;

    localparam int POS_W      = 9;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int DIM_W      = 10;
    localparam int RAD_W      = 6;
    localparam int WGT_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int CHANNELS = 3;
    localparam int CH_IDX_W = $clog2(CHANNELS);
    localparam int CH_MAX   = 255;

    localparam int WSHIFT_H  = 8;
    localparam int WSHIFT_V  = 24;
    localparam int VSPLIT_W  = 16;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = DIM_W'(512);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = DIM_W'(512);
    localparam logic [RAD_W-1:0] RST_KERNEL_RADIUS = RAD_W'(0);
    localparam logic [WGT_W-1:0] RST_KERNEL_WEIGHT = WGT_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_RADIUS = 2'd2,
        REG_KERNEL_WEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_READ  = 1'b1
    } req_type_t;

endpackage

>>> hw/rtl/sbb_frame_mem.sv
// ----------------------------------------------------------------------------
// Separable box blur frame memory
// Single write port, single read port RGB frame store with registered read.
// ----------------------------------------------------------------------------
module sbb_frame_mem
    import sbb_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem_array [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/separable_box_blur.sv
// ----------------------------------------------------------------------------
// Separable box blur, clamp to edge
// RGB frame store with store and blurred-read requests; one frame memory
// read port and one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  prefix  direction  carries
//  request  s_      in         req_type, pos_x, pos_y, in_red/green/blue
//  result   m_      out        out_red/green/blue, clipped (reads only)
//  config   cfg_    in         cfg_index, cfg_data
//
//  A store request is written while idle. In a read, each of the 2r+1 rows
//  sweeps 2r+1 taps through the single memory read port, then goes through
//  the shared multiplier; the final scaling follows on the same multiplier.
//  s_ready is high only while the sequencer is idle. A finished result sits
//  in the output register while the next request is taken.
//  Reset is synchronous on aresetn; the frame memory is not cleared.
// ----------------------------------------------------------------------------
`include "separable_box_blur_assert.svh"

module separable_box_blur
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [POS_W-1:0]      s_pos_x,
    input  logic [POS_W-1:0]      s_pos_y,
    input  logic [CH_W-1:0]       s_in_red,
    input  logic [CH_W-1:0]       s_in_green,
    input  logic [CH_W-1:0]       s_in_blue,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_out_red,
    output logic [CH_W-1:0]       m_out_green,
    output logic [CH_W-1:0]       m_out_blue,
    output logic                  m_clipped
);

    localparam int R_W      = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int SC_W     = ((POS_W > R_W) ? POS_W : R_W) + 2;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAPS_MAX = 2 * MAX_RADIUS + 1;
    localparam int HS_W     = $clog2(TAPS_MAX * CH_MAX + 1);
    localparam int HV_W     = HS_W + WGT_W - WSHIFT_H;
    localparam int VS_W     = HV_W + $clog2(TAPS_MAX + 1);
    localparam int VHI_W    = VS_W - VSPLIT_W;
    localparam int MA_T     = (HS_W > VSPLIT_W) ? HS_W : VSPLIT_W;
    localparam int MA_W     = (MA_T > VHI_W) ? MA_T : VHI_W;
    localparam int PROD_W   = MA_W + WGT_W;
    localparam int ACC_W    = VS_W + WGT_W;

    localparam logic [CH_IDX_W-1:0] FIRST_CH = '0;
    localparam logic [CH_IDX_W-1:0] LAST_CH  = CH_IDX_W'(CHANNELS - 1);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ROW     = 9'b000000010,
        ST_ROW_END = 9'b000000100,
        ST_HMUL    = 9'b000001000,
        ST_HACC    = 9'b000010000,
        ST_VLO     = 9'b000100000,
        ST_VHI     = 9'b001000000,
        ST_VSUM    = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [RAD_W-1:0] kernel_radius_reg;
    logic [WGT_W-1:0] kernel_weight_reg;

    logic [DIM_W-1:0] w_sat, h_sat;
    logic [RAD_W-1:0] r_sat;
    logic signed [SC_W-1:0] x_lim, y_lim, r_ext, px_ext, py_ext;

    logic signed [SC_W-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [SC_W-1:0] x_lo_reg, x_lo_next, x_hi_reg, x_hi_next, y_hi_reg, y_hi_next;
    logic signed [SC_W-1:0] cx, cy;

    logic [CH_IDX_W-1:0] ch_reg, ch_next;
    logic [HS_W-1:0]     hsum_reg [CHANNELS];
    logic [HS_W-1:0]     hsum_next [CHANNELS];
    logic [VS_W-1:0]     vsum_reg [CHANNELS];
    logic [VS_W-1:0]     vsum_next [CHANNELS];
    logic [CH_W-1:0]     res_reg [CHANNELS];
    logic [CH_W-1:0]     res_next [CHANNELS];
    logic                clip_reg, clip_next;

    logic [MA_W-1:0]   mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  full_sum, scaled;

    logic              rd_vld_reg, rd_vld_next;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [PIX_W-1:0]  rd_data, wr_data;
    logic [CH_W-1:0]   rd_chan [CHANNELS];

    logic              m_valid_reg, m_valid_next, load_out;
    logic [CH_W-1:0]   out_red_reg, out_green_reg, out_blue_reg;
    logic              clipped_reg;

    function automatic logic signed [SC_W-1:0] clamp_coord(
        input logic signed [SC_W-1:0] v,
        input logic signed [SC_W-1:0] lim
    );
        if (v[SC_W-1]) begin
            return '0;
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            kernel_radius_reg <= RST_KERNEL_RADIUS;
            kernel_weight_reg <= RST_KERNEL_WEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_W-1:0];
                REG_KERNEL_RADIUS: kernel_radius_reg <= cfg_data[RAD_W-1:0];
                REG_KERNEL_WEIGHT: kernel_weight_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            w_sat = DIM_W'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_sat = DIM_W'(MAX_WIDTH);
        end else begin
            w_sat = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_sat = DIM_W'(1);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            h_sat = DIM_W'(MAX_HEIGHT);
        end else begin
            h_sat = image_height_reg;
        end
        if (32'(kernel_radius_reg) > MAX_RADIUS) begin
            r_sat = RAD_W'(MAX_RADIUS);
        end else begin
            r_sat = kernel_radius_reg;
        end
    end

    assign x_lim  = $signed(SC_W'(w_sat)) - SC_W'(1);
    assign y_lim  = $signed(SC_W'(h_sat)) - SC_W'(1);
    assign r_ext  = $signed(SC_W'(r_sat));
    assign px_ext = $signed(SC_W'(s_pos_x));
    assign py_ext = $signed(SC_W'(s_pos_y));

    // tap address and store address
    assign cx      = clamp_coord(tx_reg, x_lim);
    assign cy      = clamp_coord(ty_reg, y_lim);
    assign rd_addr = ADDR_W'($unsigned(cy)) * ADDR_W'(MAX_WIDTH) + ADDR_W'($unsigned(cx));
    assign wr_addr = ADDR_W'(s_pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s_pos_x);
    assign wr_data = {s_in_red, s_in_green, s_in_blue};

    assign rd_chan[0] = rd_data[3*CH_W-1:2*CH_W];
    assign rd_chan[1] = rd_data[2*CH_W-1:CH_W];
    assign rd_chan[2] = rd_data[CH_W-1:0];

    // shared multiplier
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(kernel_weight_reg);
    assign full_sum = acc_reg + (ACC_W'(prod_reg) << VSPLIT_W);
    assign scaled   = full_sum >> WSHIFT_V;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        x_lo_next    = x_lo_reg;
        x_hi_next    = x_hi_reg;
        y_hi_next    = y_hi_reg;
        ch_next      = ch_reg;
        hsum_next    = hsum_reg;
        vsum_next    = vsum_reg;
        res_next     = res_reg;
        clip_next    = clip_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        mul_a        = '0;
        rd_en        = 1'b0;
        rd_vld_next  = 1'b0;
        wr_en        = 1'b0;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        if (rd_vld_reg) begin
            for (int c = 0; c < CHANNELS; c++) begin
                hsum_next[c] = hsum_reg[c] + HS_W'(rd_chan[c]);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_READ) begin
                        x_lo_next = px_ext - r_ext;
                        x_hi_next = px_ext + r_ext;
                        y_hi_next = py_ext + r_ext;
                        tx_next   = px_ext - r_ext;
                        ty_next   = py_ext - r_ext;
                        clip_next = 1'b0;
                        for (int c = 0; c < CHANNELS; c++) begin
                            hsum_next[c] = '0;
                            vsum_next[c] = '0;
                        end
                        state_next = ST_ROW;
                    end else if ((32'(s_pos_x) < MAX_WIDTH) && (32'(s_pos_y) < MAX_HEIGHT)) begin
                        wr_en = 1'b1;
                    end
                end
            end
            ST_ROW: begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                if (tx_reg == x_hi_reg) begin
                    state_next = ST_ROW_END;
                end else begin
                    tx_next = tx_reg + SC_W'(1);
                end
            end
            ST_ROW_END: begin
                ch_next    = FIRST_CH;
                state_next = ST_HMUL;
            end
            ST_HMUL: begin
                mul_a      = MA_W'(hsum_reg[ch_reg]);
                prod_next  = mul_p;
                state_next = ST_HACC;
            end
            ST_HACC: begin
                vsum_next[ch_reg] = vsum_reg[ch_reg] + VS_W'(prod_reg >> WSHIFT_H);
                if (ch_reg == LAST_CH) begin
                    ch_next = FIRST_CH;
                    for (int c = 0; c < CHANNELS; c++) begin
                        hsum_next[c] = '0;
                    end
                    if (ty_reg == y_hi_reg) begin
                        state_next = ST_VLO;
                    end else begin
                        ty_next    = ty_reg + SC_W'(1);
                        tx_next    = x_lo_reg;
                        state_next = ST_ROW;
                    end
                end else begin
                    ch_next    = ch_reg + CH_IDX_W'(1);
                    state_next = ST_HMUL;
                end
            end
            ST_VLO: begin
                mul_a      = MA_W'(vsum_reg[ch_reg][VSPLIT_W-1:0]);
                prod_next  = mul_p;
                state_next = ST_VHI;
            end
            ST_VHI: begin
                mul_a      = MA_W'(vsum_reg[ch_reg][VS_W-1:VSPLIT_W]);
                acc_next   = ACC_W'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_VSUM;
            end
            ST_VSUM: begin
                if (scaled > ACC_W'(CH_MAX)) begin
                    res_next[ch_reg] = CH_W'(CH_MAX);
                    clip_next        = 1'b1;
                end else begin
                    res_next[ch_reg] = scaled[CH_W-1:0];
                end
                if (ch_reg == LAST_CH) begin
                    state_next = ST_DONE;
                end else begin
                    ch_next    = ch_reg + CH_IDX_W'(1);
                    state_next = ST_VLO;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        x_lo_reg <= x_lo_next;
        x_hi_reg <= x_hi_next;
        y_hi_reg <= y_hi_next;
        ch_reg   <= ch_next;
        hsum_reg <= hsum_next;
        vsum_reg <= vsum_next;
        res_reg  <= res_next;
        clip_reg <= clip_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_red_reg   <= res_reg[0];
            out_green_reg <= res_reg[1];
            out_blue_reg  <= res_reg[2];
            clipped_reg   <= clip_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;
    assign m_clipped   = clipped_reg;

    sbb_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    `SBB_ASSERT_SAME(a_rd_data_in_row, rd_vld_reg, (state_reg == ST_ROW) || (state_reg == ST_ROW_END), "read data outside a row sweep")
    `SBB_ASSERT_NEXT(a_read_starts_row, s_valid && s_ready && (s_req_type == REQ_READ), state_reg == ST_ROW, "read request did not start a row sweep")
    `SBB_ASSERT_NEXT(a_done_loads_out, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (state_reg == ST_IDLE), "finished result not loaded")
    `SBB_ASSERT_SAME(a_clip_means_sat, m_valid && m_clipped, (m_out_red == CH_W'(CH_MAX)) || (m_out_green == CH_W'(CH_MAX)) || (m_out_blue == CH_W'(CH_MAX)), "clipped set with no saturated channel")

endmodule

>>> tb/tb_separable_box_blur.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Separable box blur testbench
// Drives store and blurred-read requests with random idle gaps on both sides, except in
// one phase. Every read is predicted against a mirror of the frame store and the register
// file, then checked field by field. A read only ever touches written pixels.
// ----------------------------------------------------------------------------
module tb_separable_box_blur;
    import sbb_pkg::*;

    localparam int FRAME_WORDS   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = 20;
    localparam int STUCK_LIMIT   = 100000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 20;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            clipped;
    } blur_pixel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [POS_W-1:0]      s_pos_x;
    logic [POS_W-1:0]      s_pos_y;
    logic [CH_W-1:0]       s_in_red;
    logic [CH_W-1:0]       s_in_green;
    logic [CH_W-1:0]       s_in_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [CH_W-1:0]       m_out_red;
    logic [CH_W-1:0]       m_out_green;
    logic [CH_W-1:0]       m_out_blue;
    logic                  m_clipped;

    logic [PIX_W-1:0] frame_mirror [0:FRAME_WORDS-1];
    bit               pixel_written [0:FRAME_WORDS-1];
    logic [DIM_W-1:0] width_cfg  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0] height_cfg = RST_IMAGE_HEIGHT;
    logic [RAD_W-1:0] radius_cfg = RST_KERNEL_RADIUS;
    logic [WGT_W-1:0] weight_cfg = RST_KERNEL_WEIGHT;

    blur_pixel_t pending_pixels [$];
    bit          sender_gaps_on   = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    int          error_count      = 0;
    int          stores_sent      = 0;
    int          reads_sent       = 0;
    int          pixels_checked   = 0;
    int          clipped_seen     = 0;
    int          settings_used    = 0;
    int          drain_pauses     = 0;

    separable_box_blur u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_clipped   (m_clipped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp_tap(int v, int lim);
        if (v < 0) return 0;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic int span(int v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int used_radius();
        return (radius_cfg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_cfg);
    endfunction

    function automatic blur_pixel_t blur_at(int cx, int cy);
        int               w, h, r, xx, yy, dx, dy, c;
        longint unsigned  wt, level;
        longint unsigned  hsum [CHANNELS];
        longint unsigned  vsum [CHANNELS];
        logic [CH_W-1:0]  chan [CHANNELS];
        logic [PIX_W-1:0] pix;
        blur_pixel_t      res;
        w  = span(width_cfg, DEF_MAX_WIDTH);
        h  = span(height_cfg, DEF_MAX_HEIGHT);
        r  = used_radius();
        wt = weight_cfg;
        res.clipped = 1'b0;
        for (c = 0; c < CHANNELS; c++) vsum[c] = 0;
        for (dy = -r; dy <= r; dy++) begin
            yy = clamp_tap(cy + dy, h);
            for (c = 0; c < CHANNELS; c++) hsum[c] = 0;
            for (dx = -r; dx <= r; dx++) begin
                xx  = clamp_tap(cx + dx, w);
                pix = frame_mirror[yy * DEF_MAX_WIDTH + xx];
                for (c = 0; c < CHANNELS; c++)
                    hsum[c] += pix[(CHANNELS - 1 - c) * CH_W +: CH_W];
            end
            for (c = 0; c < CHANNELS; c++) vsum[c] += (hsum[c] * wt) >> WSHIFT_H;
        end
        for (c = 0; c < CHANNELS; c++) begin
            level = (vsum[c] * wt) >> WSHIFT_V;
            if (level > CH_MAX) begin
                level = CH_MAX;
                res.clipped = 1'b1;
            end
            chan[c] = level[CH_W-1:0];
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        return res;
    endfunction

    task automatic send_request(req_type_t kind, int x, int y, logic [PIX_W-1:0] rgb);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_pos_x    <= POS_W'(x);
        s_pos_y    <= POS_W'(y);
        s_in_red   <= rgb[2*CH_W +: CH_W];
        s_in_green <= rgb[CH_W +: CH_W];
        s_in_blue  <= rgb[0 +: CH_W];
        do @(posedge aclk); while (!s_ready);
        if (kind == REQ_STORE) begin
            frame_mirror[y * DEF_MAX_WIDTH + x]  = rgb;
            pixel_written[y * DEF_MAX_WIDTH + x] = 1'b1;
            stores_sent++;
        end else begin
            pending_pixels.push_back(blur_at(x, y));
            reads_sent++;
        end
    endtask

    // fill any unwritten pixel of the clamped window first
    task automatic read_blurred(int x, int y);
        int r, w, h, x0, x1, y0, y1, xx, yy;
        r  = used_radius();
        w  = span(width_cfg, DEF_MAX_WIDTH);
        h  = span(height_cfg, DEF_MAX_HEIGHT);
        x0 = clamp_tap(x - r, w);
        x1 = clamp_tap(x + r, w);
        y0 = clamp_tap(y - r, h);
        y1 = clamp_tap(y + r, h);
        for (yy = y0; yy <= y1; yy++)
            for (xx = x0; xx <= x1; xx++)
                if (!pixel_written[yy * DEF_MAX_WIDTH + xx])
                    send_request(REQ_STORE, xx, yy, PIX_W'($urandom()));
        send_request(REQ_READ, x, y, PIX_W'($urandom()));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom());
        case (idx)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: data[DIM_W-1:0] = DIM_W'(value);
            REG_KERNEL_RADIUS:                 data[RAD_W-1:0] = RAD_W'(value);
            default:                           data = CFG_DATA_W'(value);
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:   width_cfg  = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  height_cfg = data[DIM_W-1:0];
            REG_KERNEL_RADIUS: radius_cfg = data[RAD_W-1:0];
            default:           weight_cfg = data[WGT_W-1:0];
        endcase
    endtask

    task automatic apply_settings(int w, int h, int r, int wt);
        wait_results_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_KERNEL_RADIUS, r);
        write_reg(REG_KERNEL_WEIGHT, wt);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_request(REQ_STORE, 0, 0, 24'h000000);
        send_request(REQ_STORE, 511, 511, 24'hFFFFFF);
        send_request(REQ_STORE, 511, 0, 24'hFF00FF);
        send_request(REQ_STORE, 0, 511, 24'h00FF00);
        send_request(REQ_STORE, 257, 170, 24'h5AA5C3);
        read_blurred(0, 0);
        read_blurred(511, 511);
        read_blurred(511, 0);
        read_blurred(0, 511);
        read_blurred(257, 170);
        wait_results_drained();
    endtask

    task automatic test_dimension_extremes();
        // width zero and height beyond the store both saturate
        apply_settings(0, 1023, 3, 65536 / 7);
        read_blurred(511, 0);
        read_blurred(0, 511);
        read_blurred(300, 300);
        apply_settings(512, 1, 5, 65536 / 11);
        read_blurred(0, 300);
        read_blurred(511, 511);
        read_blurred(250, 0);
        wait_results_drained();
    endtask

    task automatic test_weight_extremes();
        apply_settings(4, 4, 1, 0);
        read_blurred(2, 2);
        // weight just under two: 64 stays at 255 unclipped, 65 clips
        apply_settings(4, 4, 0, 131071);
        send_request(REQ_STORE, 1, 1, 24'hFF003F);
        send_request(REQ_STORE, 2, 1, 24'h3F4041);
        send_request(REQ_STORE, 3, 1, 24'h404040);
        read_blurred(1, 1);
        read_blurred(2, 1);
        read_blurred(3, 1);
        apply_settings(4, 4, 1, 131071);
        read_blurred(0, 0);
        wait_results_drained();
    endtask

    task automatic test_max_radius();
        apply_settings(8, 8, DEF_MAX_RADIUS, 65536 / (2 * DEF_MAX_RADIUS + 1));
        read_blurred(0, 0);
        read_blurred(511, 511);
        apply_settings(8, 8, DEF_MAX_RADIUS, 131071);
        read_blurred(4, 3);
        apply_settings(512, 1, DEF_MAX_RADIUS, 65536 / (2 * DEF_MAX_RADIUS + 1));
        read_blurred(255, 0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int w, h, r, wt, uw, uh, x, y, item;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            w  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
            h  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
            r  = $urandom_range(0, 6);
            wt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : 65536 / (2 * r + 1);
            apply_settings(w, h, r, wt);
            sender_gaps_on   = (phase != 1);
            receiver_gaps_on = (phase != 1);
            uw = span(w, DEF_MAX_WIDTH);
            uh = span(h, DEF_MAX_HEIGHT);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                if (item == PHASE_ITEMS / 2 || $urandom_range(0, 9) == 0) begin
                    wait_results_drained();
                    drain_pauses++;
                end
                if ($urandom_range(0, 9) < 6) begin
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 511);
                    if ($urandom_range(0, 9) < 7) begin
                        x = $urandom_range(0, (uw + r > 511) ? 511 : uw + r);
                        y = $urandom_range(0, (uh + r > 511) ? 511 : uh + r);
                    end
                    read_blurred(x, y);
                end else begin
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 511);
                    if ($urandom_range(0, 9) < 6) begin
                        x = $urandom_range(0, uw - 1);
                        y = $urandom_range(0, uh - 1);
                    end
                    send_request(REQ_STORE, x, y, PIX_W'($urandom()));
                end
            end
        end
        sender_gaps_on   = 1'b1;
        receiver_gaps_on = 1'b1;
        wait_results_drained();
    endtask

    // result side: stall before or after valid shows up
    initial begin
        int stall;
        bit late;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = receiver_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            late  = receiver_gaps_on ? bit'($urandom_range(0, 1)) : 1'b0;
            if (stall != 0 || late) m_ready <= 1'b0;
            if (late) do @(posedge aclk); while (!m_valid);
            repeat (stall) @(posedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        blur_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0d %0d %0d clip %0d",
                         $time, m_out_red, m_out_green, m_out_blue, m_clipped);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, m_out_red);
                check_field("green", want.green, m_out_green);
                check_field("blue", want.blue, m_out_blue);
                check_field("clipped", want.clipped, m_clipped);
                pixels_checked++;
                if (want.clipped) clipped_seen++;
            end
        end
    end

    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_IMAGE_WIDTH;
        cfg_data   <= '0;
        s_valid    <= 1'b0;
        s_req_type <= REQ_STORE;
        s_pos_x    <= '0;
        s_pos_y    <= '0;
        s_in_red   <= '0;
        s_in_green <= '0;
        s_in_blue  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_dimension_extremes();
        test_weight_extremes();
        test_max_radius();
        test_random_traffic();
        $display("Run covered %0d stores and %0d blurred reads over %0d register settings.",
                 stores_sent, reads_sent, settings_used);
        $display("Checked %0d results, %0d of them clipped; sender drained %0d times.",
                 pixels_checked, clipped_seen, drain_pauses);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
